// File: hdl/c2rtc_pkg.sv
// Shared types, constants and the byte encoder for the calendar to RTC
// register converter. No dependencies.
`default_nettype none

package c2rtc_pkg;

  localparam int unsigned FieldW   = 8;
  localparam int unsigned YearW    = 14;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 1;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_TWENTY_FOUR_HOUR = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BINARY           = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTURY          = 2'd2;

  localparam logic [FieldW-1:0] HOUR_MAX    = 8'd23;
  localparam logic [FieldW-1:0] MINSEC_MAX  = 8'd59;
  localparam logic [FieldW-1:0] DAY_MAX     = 8'd31;
  localparam logic [FieldW-1:0] MONTH_MAX   = 8'd12;
  localparam logic [FieldW-1:0] WEEKDAY_MAX = 8'd7;
  localparam logic [FieldW-1:0] HOUR_NOON   = 8'd12;
  localparam logic [YearW-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [FieldW-1:0] PM_FLAG     = 8'h80;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y.
  localparam int unsigned       CentShift = 19;
  localparam logic [12:0]       CentRecip = 13'd5243;

  typedef struct packed {
    logic twenty_four_hour;
    logic binary;
    logic century;
  } c2rtc_cfg_t;

  // Packs a value below 100 as two BCD digits, or passes it through in
  // binary mode. floor(v / 10) == (v * 205) >> 11 for every 8-bit v.
  function automatic logic [FieldW-1:0] encode_byte(input logic [FieldW-1:0] v,
                                                    input logic binary);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  units;
    prod  = {8'd0, v} * 16'd205;
    tens  = prod[15:11];
    units = v - ({3'd0, tens} * 8'd10);
    if (binary) begin
      encode_byte = v;
    end else begin
      encode_byte = {tens[3:0], units[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/calendar_to_rtc_registers.sv
// Calendar to RTC register converter: checks one calendar time and packs it
// into MC146818-style register bytes. Depends on c2rtc_pkg.
//
//  Channel   Direction  Handshake                    Payload
//  in        sink       in_valid_i / in_ready_o      hour .. weekday, full_year
//  out       source     out_valid_o / out_ready_i    status, bytes, century_write
//  cfg       sink       cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
// Two stages: a request is captured in the input register, then converted
// into the result register, so one request can be taken every cycle while
// the result is not stalled. The depth is set by the year split multiplier
// and the BCD packing between the two registers.
// Reset clears the valid flags and the three mode bits.
// A stalled result holds the result register; the input register keeps
// taking requests until both stages are full.
`default_nettype none

module calendar_to_rtc_registers (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [c2rtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [c2rtc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [c2rtc_pkg::FieldW-1:0]   hour_i,
  input  wire logic [c2rtc_pkg::FieldW-1:0]   minute_i,
  input  wire logic [c2rtc_pkg::FieldW-1:0]   second_i,
  input  wire logic [c2rtc_pkg::FieldW-1:0]   day_i,
  input  wire logic [c2rtc_pkg::FieldW-1:0]   month_i,
  input  wire logic [c2rtc_pkg::YearW-1:0]    full_year_i,
  input  wire logic [c2rtc_pkg::FieldW-1:0]   weekday_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                status_o,
  output logic [c2rtc_pkg::FieldW-1:0]        hour_byte_o,
  output logic [c2rtc_pkg::FieldW-1:0]        minute_byte_o,
  output logic [c2rtc_pkg::FieldW-1:0]        second_byte_o,
  output logic [c2rtc_pkg::FieldW-1:0]        day_byte_o,
  output logic [c2rtc_pkg::FieldW-1:0]        month_byte_o,
  output logic [c2rtc_pkg::FieldW-1:0]        year_byte_o,
  output logic [c2rtc_pkg::FieldW-1:0]        weekday_byte_o,
  output logic [c2rtc_pkg::FieldW-1:0]        century_byte_o,
  output logic                                century_write_o
);
  import c2rtc_pkg::*;

  c2rtc_cfg_t cfg_q;

  logic              s1_valid_q;
  logic [FieldW-1:0] s1_hour_q, s1_minute_q, s1_second_q, s1_day_q;
  logic [FieldW-1:0] s1_month_q, s1_weekday_q;
  logic [YearW-1:0]  s1_year_q;

  logic              out_valid_q;
  logic              status_q, century_write_q;
  logic [FieldW-1:0] hour_byte_q, minute_byte_q, second_byte_q, day_byte_q;
  logic [FieldW-1:0] month_byte_q, year_byte_q, weekday_byte_q, century_byte_q;

  logic              s1_advance;
  logic              in_accept;
  logic              bad;
  logic              pm;
  logic [FieldW-1:0] hour12;
  logic [26:0]       cent_prod;
  logic [7:0]        century;
  logic [YearW-1:0]  cent_x100;
  logic [YearW-1:0]  year_lo;

  logic              status_d, century_write_d;
  logic [FieldW-1:0] hour_byte_d, minute_byte_d, second_byte_d, day_byte_d;
  logic [FieldW-1:0] month_byte_d, year_byte_d, weekday_byte_d, century_byte_d;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TWENTY_FOUR_HOUR: cfg_q.twenty_four_hour <= cfg_data_i[0];
        REG_BINARY:           cfg_q.binary           <= cfg_data_i[0];
        REG_CENTURY:          cfg_q.century          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_hour_q    <= hour_i;
      s1_minute_q  <= minute_i;
      s1_second_q  <= second_i;
      s1_day_q     <= day_i;
      s1_month_q   <= month_i;
      s1_year_q    <= full_year_i;
      s1_weekday_q <= weekday_i;
    end
  end

  always_comb begin
    bad = (s1_hour_q > HOUR_MAX) || (s1_minute_q > MINSEC_MAX) ||
          (s1_second_q > MINSEC_MAX) || (s1_day_q == '0) || (s1_day_q > DAY_MAX) ||
          (s1_month_q == '0) || (s1_month_q > MONTH_MAX) ||
          (s1_weekday_q == '0) || (s1_weekday_q > WEEKDAY_MAX) ||
          (s1_year_q > YEAR_MAX);

    // Century by reciprocal multiply; the remainder uses shift-adds for x100.
    cent_prod = {13'd0, s1_year_q} * {14'd0, CentRecip};
    century   = cent_prod[CentShift+7:CentShift];
    cent_x100 = {century[7:0], 6'd0} + {1'b0, century[7:0], 5'd0} +
                {4'd0, century[7:0], 2'd0};
    year_lo   = s1_year_q - cent_x100;

    pm = s1_hour_q >= HOUR_NOON;
    if (s1_hour_q == '0) begin
      hour12 = HOUR_NOON;
    end else if (s1_hour_q > HOUR_NOON) begin
      hour12 = s1_hour_q - HOUR_NOON;
    end else begin
      hour12 = s1_hour_q;
    end

    status_d        = bad;
    hour_byte_d     = '0;
    minute_byte_d   = '0;
    second_byte_d   = '0;
    day_byte_d      = '0;
    month_byte_d    = '0;
    year_byte_d     = '0;
    weekday_byte_d  = '0;
    century_byte_d  = '0;
    century_write_d = 1'b0;
    if (!bad) begin
      if (cfg_q.twenty_four_hour) begin
        hour_byte_d = encode_byte(s1_hour_q, cfg_q.binary);
      end else begin
        // The PM flag goes in after packing, so it survives BCD mode.
        hour_byte_d = encode_byte(hour12, cfg_q.binary) | (pm ? PM_FLAG : '0);
      end
      minute_byte_d  = encode_byte(s1_minute_q, cfg_q.binary);
      second_byte_d  = encode_byte(s1_second_q, cfg_q.binary);
      day_byte_d     = encode_byte(s1_day_q, cfg_q.binary);
      month_byte_d   = encode_byte(s1_month_q, cfg_q.binary);
      year_byte_d    = encode_byte(year_lo[FieldW-1:0], cfg_q.binary);
      weekday_byte_d = encode_byte(s1_weekday_q, cfg_q.binary);
      if (cfg_q.century) begin
        century_byte_d  = encode_byte(century, cfg_q.binary);
        century_write_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      status_q        <= status_d;
      hour_byte_q     <= hour_byte_d;
      minute_byte_q   <= minute_byte_d;
      second_byte_q   <= second_byte_d;
      day_byte_q      <= day_byte_d;
      month_byte_q    <= month_byte_d;
      year_byte_q     <= year_byte_d;
      weekday_byte_q  <= weekday_byte_d;
      century_byte_q  <= century_byte_d;
      century_write_q <= century_write_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign hour_byte_o     = hour_byte_q;
  assign minute_byte_o   = minute_byte_q;
  assign second_byte_o   = second_byte_q;
  assign day_byte_o      = day_byte_q;
  assign month_byte_o    = month_byte_q;
  assign year_byte_o     = year_byte_q;
  assign weekday_byte_o  = weekday_byte_q;
  assign century_byte_o  = century_byte_q;
  assign century_write_o = century_write_q;

  // An invalid request carries only its status bit.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> hour_byte_o == '0 && century_write_o == 1'b0 &&
                                century_byte_o == '0)
    else $error("invalid request produced non-zero register bytes");

  // Back-pressure reaches the input only when both stages hold a request.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with a free stage");

  // An accepted request always lands in the input register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted request lost");

endmodule

`default_nettype wire
